FILE: rtl/core/ihpq_pkg.sv
// ----------------------------------------------------------------------------
// ihpq_pkg
// Types and constants for the indexed max-heap priority queue core.
// ----------------------------------------------------------------------------
package ihpq_pkg;

    localparam int CAPACITY  = 256;
    localparam int KEY_BITS  = 32;
    localparam int SLOT_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_RAISE  = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_FULL       = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_UNUSED     = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  handle;
        logic [31:0] key;
    } in_item_t;

    typedef struct packed {
        logic [31:0] top_key;
        logic [7:0]  top_handle;
        logic        is_empty;
        logic [8:0]  entry_total;
        logic [1:0]  status;
    } out_item_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RAISE_POS,
        S_RAISE_CHK,
        S_DEL_LAST,
        S_DEL_WAIT,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_L,
        S_DN_R,
        S_ROOT_RD,
        S_ROOT_WAIT,
        S_OUT
    } state_t;

endpackage

FILE: rtl/core/indexed_max_heap_priority_queue_core.sv
// ----------------------------------------------------------------------------
// indexed_max_heap_priority_queue_core
// Indexed binary max-heap with handle-to-slot map, sifts run on block RAMs.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake     Payload
// in       in   valid/stall   ihpq_pkg::in_item_t  (func, handle, key)
// out      out  valid/stall   ihpq_pkg::out_item_t (root, count, status)
//
// One transaction in flight at a time. A sift-up level reads the parent,
// then compares; a sift-down level reads the left child, weighs it while
// reading the right, then weighs the right; the root is read last. A
// delete-max sifts from the root down to a leaf at most. The single read
// port of the slot memory serializes these reads. Reset clears the count,
// sequencer and output valid only; memories need no clearing. The input
// is stalled while an item is being worked on or its result waits.
// ----------------------------------------------------------------------------
module indexed_max_heap_priority_queue_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ihpq_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ihpq_pkg::out_item_t out_data
);

    localparam int SB = ihpq_pkg::SLOT_BITS;
    localparam int CB = ihpq_pkg::CNT_BITS;
    localparam int KB = ihpq_pkg::KEY_BITS;

    // Memories: slot entries {handle,key} and handle position map
    logic [8+KB-1:0] slot_mem [ihpq_pkg::CAPACITY];
    logic [SB-1:0]   pos_mem  [256];

    logic            sw_en;
    logic [SB-1:0]   sw_addr;
    logic [8+KB-1:0] sw_data;
    logic [SB-1:0]   sr_addr;
    logic [8+KB-1:0] sr_q;
    logic            pw_en;
    logic [7:0]      pw_addr;
    logic [SB-1:0]   pw_data;
    logic [7:0]      pr_addr;
    logic [SB-1:0]   pr_q;

    always_ff @(posedge clk)
    begin
        if (sw_en)
        begin
            slot_mem[sw_addr] <= sw_data;
        end
        sr_q <= slot_mem[sr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pw_en)
        begin
            pos_mem[pw_addr] <= pw_data;
        end
        pr_q <= pos_mem[pr_addr];
    end

    // Registers
    ihpq_pkg::state_t   state_reg, state_next;
    logic [CB-1:0]      count_reg, count_next;
    logic [SB-1:0]      idx_reg, idx_next;      // current slot of moving entry
    logic [7:0]         mh_reg, mh_next;        // moving handle
    logic [KB-1:0]      mk_reg, mk_next;        // moving key
    logic [SB-1:0]      best_reg, best_next;    // largest child slot
    logic [8+KB-1:0]    bestv_reg, bestv_next;  // largest child entry
    logic               bval_reg, bval_next;    // a child beat the mover
    logic               dup_reg, dup_next;      // last displaced entry had mover's handle
    logic [1:0]         status_reg, status_next;
    logic               ov_reg, ov_next;
    ihpq_pkg::out_item_t od_reg, od_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ihpq_pkg::S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        mh_reg     <= mh_next;
        mk_reg     <= mk_next;
        best_reg   <= best_next;
        bestv_reg  <= bestv_next;
        bval_reg   <= bval_next;
        dup_reg    <= dup_next;
        status_reg <= status_next;
        od_reg     <= od_next;
    end

    assign in_stall  = (state_reg != ihpq_pkg::S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    logic [SB-1:0]   parent;
    logic [SB:0]     left_w;
    logic [SB:0]     right_w;
    logic [KB-1:0]   rd_key;
    logic [7:0]      rd_handle;
    logic [KB-1:0]   cmp_key;

    assign parent    = SB'((idx_reg - 1'b1) >> 1);
    assign left_w    = {idx_reg, 1'b1};
    assign right_w   = (SB + 1)'({idx_reg, 1'b0}) + (SB + 1)'(2);
    assign rd_key    = sr_q[KB-1:0];
    assign rd_handle = sr_q[8+KB-1:KB];
    assign cmp_key   = bval_reg ? bestv_reg[KB-1:0] : mk_reg;

    // Sequencer
    // When the last displaced entry carried the mover's own handle, its map
    // write is the one that stands, so the mover's final map write is dropped.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        mh_next     = mh_reg;
        mk_next     = mk_reg;
        best_next   = best_reg;
        bestv_next  = bestv_reg;
        bval_next   = bval_reg;
        dup_next    = dup_reg;
        status_next = status_reg;
        ov_next     = ov_reg && out_stall;
        od_next     = od_reg;
        sw_en       = 1'b0;
        sw_addr     = idx_reg;
        sw_data     = {mh_reg, mk_reg};
        sr_addr     = idx_reg;
        pw_en       = 1'b0;
        pw_addr     = mh_reg;
        pw_data     = idx_reg;
        pr_addr     = in_data.handle;

        case (state_reg)
            ihpq_pkg::S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    mh_next     = in_data.handle;
                    mk_next     = in_data.key[KB-1:0];
                    dup_next    = 1'b0;
                    status_next = ihpq_pkg::ST_DONE;
                    case (ihpq_pkg::func_t'(in_data.func))
                        ihpq_pkg::FUNC_INSERT:
                        begin
                            if (count_reg >= CB'(ihpq_pkg::CAPACITY))
                            begin
                                status_next = ihpq_pkg::ST_FULL;
                                state_next  = ihpq_pkg::S_ROOT_RD;
                            end
                            else
                            begin
                                idx_next   = count_reg[SB-1:0];
                                count_next = count_reg + 1'b1;
                                state_next = ihpq_pkg::S_UP_RD;
                            end
                        end
                        ihpq_pkg::FUNC_RAISE:
                        begin
                            state_next = ihpq_pkg::S_RAISE_POS;
                        end
                        ihpq_pkg::FUNC_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ihpq_pkg::ST_EMPTY;
                                state_next  = ihpq_pkg::S_ROOT_RD;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                state_next = ihpq_pkg::S_DEL_LAST;
                            end
                        end
                        default:
                        begin
                            state_next = ihpq_pkg::S_ROOT_RD;
                        end
                    endcase
                end
            end

            // Position read done; fetch mapped slot
            ihpq_pkg::S_RAISE_POS:
            begin
                idx_next   = pr_q;
                sr_addr    = pr_q;
                state_next = ihpq_pkg::S_RAISE_CHK;
            end

            ihpq_pkg::S_RAISE_CHK:
            begin
                if ((CB'(idx_reg) < count_reg) && (rd_handle == mh_reg))
                begin
                    state_next = ihpq_pkg::S_UP_RD;
                end
                else
                begin
                    state_next = ihpq_pkg::S_ROOT_RD;
                end
            end

            // Read last slot (count already decremented)
            ihpq_pkg::S_DEL_LAST:
            begin
                sr_addr    = count_reg[SB-1:0];
                state_next = ihpq_pkg::S_DEL_WAIT;
            end

            ihpq_pkg::S_DEL_WAIT:
            begin
                mh_next    = rd_handle;
                mk_next    = rd_key;
                idx_next   = '0;
                state_next = (count_reg == '0) ? ihpq_pkg::S_ROOT_RD : ihpq_pkg::S_DN_RD;
            end

            // Sift up: mover sits (logically) at idx; read parent
            ihpq_pkg::S_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    sw_en      = 1'b1;
                    pw_en      = !dup_reg;
                    state_next = ihpq_pkg::S_ROOT_RD;
                end
                else
                begin
                    sr_addr    = parent;
                    state_next = ihpq_pkg::S_UP_CMP;
                end
            end

            ihpq_pkg::S_UP_CMP:
            begin
                if (rd_key < mk_reg)
                begin
                    // move parent down into idx
                    sw_en      = 1'b1;
                    sw_data    = sr_q;
                    pw_en      = 1'b1;
                    pw_addr    = rd_handle;
                    dup_next   = (rd_handle == mh_reg);
                    idx_next   = parent;
                    state_next = ihpq_pkg::S_UP_RD;
                end
                else
                begin
                    sw_en      = 1'b1;
                    pw_en      = !dup_reg;
                    state_next = ihpq_pkg::S_ROOT_RD;
                end
            end

            // Sift down: read left child
            ihpq_pkg::S_DN_RD:
            begin
                bval_next = 1'b0;
                if (left_w < (SB + 1)'(count_reg))
                begin
                    sr_addr    = left_w[SB-1:0];
                    state_next = ihpq_pkg::S_DN_L;
                end
                else
                begin
                    sw_en      = 1'b1;
                    pw_en      = !dup_reg;
                    state_next = ihpq_pkg::S_ROOT_RD;
                end
            end

            ihpq_pkg::S_DN_L:
            begin
                if (rd_key > mk_reg)
                begin
                    bval_next  = 1'b1;
                    best_next  = left_w[SB-1:0];
                    bestv_next = sr_q;
                end
                sr_addr    = right_w[SB-1:0];
                state_next = ihpq_pkg::S_DN_R;
            end

            ihpq_pkg::S_DN_R:
            begin
                if ((right_w < (SB + 1)'(count_reg)) && (rd_key > cmp_key))
                begin
                    sw_en      = 1'b1;
                    sw_data    = sr_q;
                    pw_en      = 1'b1;
                    pw_addr    = rd_handle;
                    dup_next   = (rd_handle == mh_reg);
                    idx_next   = right_w[SB-1:0];
                    state_next = ihpq_pkg::S_DN_RD;
                end
                else if (bval_reg)
                begin
                    sw_en      = 1'b1;
                    sw_data    = bestv_reg;
                    pw_en      = 1'b1;
                    pw_addr    = bestv_reg[8+KB-1:KB];
                    dup_next   = (bestv_reg[8+KB-1:KB] == mh_reg);
                    idx_next   = best_reg;
                    state_next = ihpq_pkg::S_DN_RD;
                end
                else
                begin
                    sw_en      = 1'b1;
                    pw_en      = !dup_reg;
                    state_next = ihpq_pkg::S_ROOT_RD;
                end
            end

            ihpq_pkg::S_ROOT_RD:
            begin
                sr_addr    = '0;
                state_next = ihpq_pkg::S_ROOT_WAIT;
            end

            ihpq_pkg::S_ROOT_WAIT:
            begin
                od_next.top_key     = (count_reg == '0) ? '0 : 32'(rd_key);
                od_next.top_handle  = (count_reg == '0) ? '0 : rd_handle;
                od_next.is_empty    = (count_reg == '0);
                od_next.entry_total = 9'(count_reg);
                od_next.status      = status_reg;
                ov_next             = 1'b1;
                state_next          = ihpq_pkg::S_OUT;
            end

            ihpq_pkg::S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    state_next = ihpq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ihpq_pkg::S_IDLE;
            end
        endcase
    end

endmodule
